@@ hdl/um32_pkg.sv @@
// um32_pkg: shared types and constants for the um32 register execute unit
// payload structs, opcode and action codes, shared unit command/status
// no dependencies
package um32_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegAW   = 3;

  // request beat
  typedef struct packed {
    logic [1:0]       req_type;
    logic [WordW-1:0] instruction_word;
    logic [7:0]       in_byte;
    logic             in_end;
    logic [WordW-1:0] return_value;
  } um32_req_t;

  // result beat
  typedef struct packed {
    logic [3:0]       action;
    logic [WordW-1:0] arg_a;
    logic [WordW-1:0] arg_b;
    logic [WordW-1:0] arg_c;
  } um32_rsp_t;

  // request kinds
  localparam logic [1:0] REQ_INSN     = 2'd0;
  localparam logic [1:0] REQ_LOAD_RET = 2'd1;
  localparam logic [1:0] REQ_MAP_RET  = 2'd2;

  // action codes
  localparam logic [3:0] ACT_NONE     = 4'd0;
  localparam logic [3:0] ACT_OUT      = 4'd1;
  localparam logic [3:0] ACT_LOAD     = 4'd2;
  localparam logic [3:0] ACT_STORE    = 4'd3;
  localparam logic [3:0] ACT_MAP      = 4'd4;
  localparam logic [3:0] ACT_UNMAP    = 4'd5;
  localparam logic [3:0] ACT_LOADPROG = 4'd6;
  localparam logic [3:0] ACT_HALT     = 4'd7;
  localparam logic [3:0] ACT_DIVZERO  = 4'd8;
  localparam logic [3:0] ACT_BADOP    = 4'd9;
  localparam logic [3:0] ACT_STRAY    = 4'd10;

  // opcodes
  localparam logic [3:0] OP_CMOV   = 4'd0;
  localparam logic [3:0] OP_SLOAD  = 4'd1;
  localparam logic [3:0] OP_SSTORE = 4'd2;
  localparam logic [3:0] OP_ADD    = 4'd3;
  localparam logic [3:0] OP_MUL    = 4'd4;
  localparam logic [3:0] OP_DIV    = 4'd5;
  localparam logic [3:0] OP_NAND   = 4'd6;
  localparam logic [3:0] OP_HALT   = 4'd7;
  localparam logic [3:0] OP_MAP    = 4'd8;
  localparam logic [3:0] OP_UNMAP  = 4'd9;
  localparam logic [3:0] OP_OUT    = 4'd10;
  localparam logic [3:0] OP_IN     = 4'd11;
  localparam logic [3:0] OP_LOADP  = 4'd12;
  localparam logic [3:0] OP_ORTH   = 4'd13;

  // shared arithmetic unit
  typedef enum logic [1:0] {
    ALU_ADD  = 2'd0,
    ALU_MUL  = 2'd1,
    ALU_NAND = 2'd2,
    ALU_DIV  = 2'd3
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] result;
  } alu_rsp_t;

endpackage

@@ hdl/um32_ram.sv @@
// um32_ram: generic ram, one write port, two registered read ports
// no dependencies
module um32_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr0_i,
  input  logic [AddrW-1:0] raddr1_i,
  output logic [Width-1:0] rdata0_o,
  output logic [Width-1:0] rdata1_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata0_q;
  logic [Width-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

@@ hdl/um32_alu.sv @@
// um32_alu: shared arithmetic unit, add/mul/nand with a registered result,
// unsigned divide one quotient bit per cycle on the shared adder
// depends on um32_pkg
module um32_alu (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  um32_pkg::alu_req_t            req_i,
  input  logic [um32_pkg::WordW-1:0]    opb_i,
  input  logic [um32_pkg::WordW-1:0]    opc_i,
  output um32_pkg::alu_rsp_t            rsp_o
);
  import um32_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [WordW-1:0] rem_q, rem_d;
  logic [WordW-1:0] quo_q, quo_d;
  logic [WordW-1:0] dvs_q, dvs_d;
  logic [WordW-1:0] res_q, res_d;

  // shared adder, two guard bits so the sign of a trial subtract is visible
  logic [WordW+1:0] add_x, add_y, add_sum;
  logic             add_cin;
  logic [WordW-1:0] prod;
  logic             qbit;

  always_comb begin
    if (busy_q) begin
      add_x   = {1'b0, rem_q, quo_q[WordW-1]};
      add_y   = ~{2'b00, dvs_q};
      add_cin = 1'b1;
    end else begin
      add_x   = {2'b00, opb_i};
      add_y   = {2'b00, opc_i};
      add_cin = 1'b0;
    end
  end

  assign add_sum = add_x + add_y + {{(WordW+1){1'b0}}, add_cin};
  assign prod    = opb_i * opc_i;
  assign qbit    = ~add_sum[WordW+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    res_d  = res_q;
    if (busy_q) begin
      // restoring step
      rem_d = qbit ? add_sum[WordW-1:0] : add_x[WordW-1:0];
      quo_d = {quo_q[WordW-2:0], qbit};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = {quo_q[WordW-2:0], qbit};
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end else if (req_i.start) begin
      case (req_i.op)
        ALU_ADD: begin
          res_d  = add_sum[WordW-1:0];
          done_d = 1'b1;
        end
        ALU_MUL: begin
          res_d  = prod;
          done_d = 1'b1;
        end
        ALU_NAND: begin
          res_d  = ~(opb_i & opc_i);
          done_d = 1'b1;
        end
        ALU_DIV: begin
          busy_d = 1'b1;
          cnt_d  = 5'd31;
          rem_d  = '0;
          quo_d  = opb_i;
          dvs_d  = opc_i;
        end
        default: begin
          done_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

@@ hdl/um32_register_execute_unit.sv @@
// um32_register_execute_unit: top level, decode/execute sequencer, register file
// valid bits, pending load/map destination, result register
// depends on um32_pkg, um32_ram, um32_alu
//
//   channel   direction  handshake               payload
//   request   in         req_valid_i/req_ready_o req_i  (um32_req_t)
//   result    out        rsp_valid_o/rsp_ready_i rsp_o  (um32_rsp_t)
//
// one item at a time; req_ready_o is high only while the sequencer is idle
// a return beat goes straight to writeback; an instruction reads the
// register file ram (registered reads), executes, writes back; a store
// also reads A; alu ops wait on the alu, divide one quotient bit per cycle
// a finished result waits in the result register; the next beat is accepted
// meanwhile and only its writeback stalls until the result is taken
// reset clears all control state; registers read as zero until first written
module um32_register_execute_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  um32_pkg::um32_req_t req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output um32_pkg::um32_rsp_t rsp_o
);
  import um32_pkg::*;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_EX   = 6'b000100,
    S_RDA  = 6'b001000,
    S_ALU  = 6'b010000,
    S_WB   = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  um32_req_t        req_q, req_d;
  logic [WordW-1:0] vb_q, vb_d;
  logic [WordW-1:0] vc_q, vc_d;
  logic [NumRegs-1:0] vld_q, vld_d;
  logic             rvld0_q, rvld1_q;
  logic [RegAW-1:0] pend_dest_q, pend_dest_d;
  logic             pend_vld_q, pend_vld_d;
  logic             wb_en_q, wb_en_d;
  logic [RegAW-1:0] wb_addr_q, wb_addr_d;
  logic [WordW-1:0] wb_data_q, wb_data_d;
  um32_rsp_t        res_q, res_d;
  um32_rsp_t        rsp_q, rsp_d;
  logic             rsp_valid_q, rsp_valid_d;

  logic             req_acc;
  logic             out_free;
  logic             ram_we;
  logic [RegAW-1:0] raddr0, raddr1;
  logic [WordW-1:0] rdata0, rdata1;
  logic [WordW-1:0] vb, vc;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  // instruction fields of the latched beat
  logic [3:0]       opcode;
  logic [RegAW-1:0] ia, ib, ic, lit_a;
  logic [24:0]      lit_v;

  assign opcode = req_q.instruction_word[31:28];
  assign ia     = req_q.instruction_word[8:6];
  assign ib     = req_q.instruction_word[5:3];
  assign ic     = req_q.instruction_word[2:0];
  assign lit_a  = req_q.instruction_word[27:25];
  assign lit_v  = req_q.instruction_word[24:0];

  assign req_ready_o = (state_q == S_IDLE);
  assign req_acc     = req_valid_i && req_ready_o;
  assign out_free    = !rsp_valid_q || rsp_ready_i;

  // register file: port 0 reads B, then A for a store; port 1 reads C
  assign raddr0 = (state_q == S_EX) ? ia : ib;
  assign raddr1 = ic;
  assign ram_we = (state_q == S_WB) && out_free && wb_en_q;

  um32_ram #(
    .Width (WordW),
    .Depth (NumRegs)
  ) u_regs (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (wb_addr_q),
    .wdata_i  (wb_data_q),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  // never-written registers read as zero
  assign vb = rvld0_q ? rdata0 : '0;
  assign vc = rvld1_q ? rdata1 : '0;

  um32_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .opb_i  (vb),
    .opc_i  (vc),
    .rsp_o  (alu_rsp)
  );

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    vb_d        = vb_q;
    vc_d        = vc_q;
    vld_d       = vld_q;
    pend_dest_d = pend_dest_q;
    pend_vld_d  = pend_vld_q;
    wb_en_d     = wb_en_q;
    wb_addr_d   = wb_addr_q;
    wb_data_d   = wb_data_q;
    res_d       = res_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q;
    alu_req     = '{start: 1'b0, op: ALU_ADD};

    // result register drains independently of the sequencer
    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          req_d   = req_i;
          wb_en_d = 1'b0;
          res_d   = '0;
          case (req_i.req_type)
            REQ_INSN: begin
              state_d = S_RD;
            end
            REQ_LOAD_RET, REQ_MAP_RET: begin
              // answer goes to the remembered destination whatever its kind
              if (pend_vld_q) begin
                wb_en_d    = 1'b1;
                wb_addr_d  = pend_dest_q;
                wb_data_d  = req_i.return_value;
                pend_vld_d = 1'b0;
              end else begin
                res_d.action = ACT_STRAY;
              end
              state_d = S_WB;
            end
            default: begin
              state_d = S_WB;
            end
          endcase
        end
      end

      S_RD: begin
        state_d = S_EX;
      end

      S_EX: begin
        vb_d      = vb;
        vc_d      = vc;
        wb_en_d   = 1'b0;
        wb_addr_d = ia;
        res_d     = '0;
        state_d   = S_WB;
        case (opcode)
          OP_CMOV: begin
            wb_en_d   = (vc != '0);
            wb_data_d = vb;
          end
          OP_SLOAD: begin
            pend_dest_d  = ia;
            pend_vld_d   = 1'b1;
            res_d.action = ACT_LOAD;
            res_d.arg_a  = vb;
            res_d.arg_b  = vc;
          end
          OP_SSTORE: begin
            // register A comes out of port 0 next cycle
            state_d = S_RDA;
          end
          OP_ADD: begin
            alu_req = '{start: 1'b1, op: ALU_ADD};
            state_d = S_ALU;
          end
          OP_MUL: begin
            alu_req = '{start: 1'b1, op: ALU_MUL};
            state_d = S_ALU;
          end
          OP_DIV: begin
            if (vc == '0) begin
              res_d.action = ACT_DIVZERO;
            end else begin
              alu_req = '{start: 1'b1, op: ALU_DIV};
              state_d = S_ALU;
            end
          end
          OP_NAND: begin
            alu_req = '{start: 1'b1, op: ALU_NAND};
            state_d = S_ALU;
          end
          OP_HALT: begin
            res_d.action = ACT_HALT;
          end
          OP_MAP: begin
            pend_dest_d  = ib;
            pend_vld_d   = 1'b1;
            res_d.action = ACT_MAP;
            res_d.arg_a  = vc;
          end
          OP_UNMAP: begin
            res_d.action = ACT_UNMAP;
            res_d.arg_a  = vc;
          end
          OP_OUT: begin
            res_d.action = ACT_OUT;
            res_d.arg_a  = {{(WordW-8){1'b0}}, vc[7:0]};
          end
          OP_IN: begin
            wb_en_d   = 1'b1;
            wb_addr_d = ic;
            wb_data_d = req_q.in_end ? '1 : {{(WordW-8){1'b0}}, req_q.in_byte};
          end
          OP_LOADP: begin
            res_d.action = ACT_LOADPROG;
            res_d.arg_a  = vb;
            res_d.arg_b  = vc;
          end
          OP_ORTH: begin
            wb_en_d   = 1'b1;
            wb_addr_d = lit_a;
            wb_data_d = {{(WordW-25){1'b0}}, lit_v};
          end
          default: begin
            res_d.action = ACT_BADOP;
          end
        endcase
      end

      S_RDA: begin
        res_d.action = ACT_STORE;
        res_d.arg_a  = vb;
        res_d.arg_b  = vb_q;
        res_d.arg_c  = vc_q;
        state_d      = S_WB;
      end

      S_ALU: begin
        if (alu_rsp.done) begin
          wb_en_d   = 1'b1;
          wb_data_d = alu_rsp.result;
          state_d   = S_WB;
        end
      end

      S_WB: begin
        // commit the register write together with the result beat
        if (out_free) begin
          rsp_d       = res_q;
          rsp_valid_d = 1'b1;
          if (wb_en_q) begin
            vld_d[wb_addr_q] = 1'b1;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vld_q       <= '0;
      rvld0_q     <= 1'b0;
      rvld1_q     <= 1'b0;
      pend_dest_q <= '0;
      pend_vld_q  <= 1'b0;
      wb_en_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vld_q       <= vld_d;
      rvld0_q     <= vld_q[raddr0];
      rvld1_q     <= vld_q[raddr1];
      pend_dest_q <= pend_dest_d;
      pend_vld_q  <= pend_vld_d;
      wb_en_q     <= wb_en_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    vb_q      <= vb_d;
    vc_q      <= vc_d;
    wb_addr_q <= wb_addr_d;
    wb_data_q <= wb_data_d;
    res_q     <= res_d;
    rsp_q     <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // a new result beat only ever comes out of writeback
  a_rsp_from_wb : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> $past(state_q == S_WB))
    else $error("result beat raised outside writeback");

  // the alu reports completion only while the sequencer waits on it
  a_alu_done_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q == S_ALU))
    else $error("alu done while sequencer not waiting");

  // a zero divisor never reaches the divider
  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (alu_req.start && (alu_req.op == ALU_DIV)) |-> (vc != '0))
    else $error("divide started with zero divisor");

  // any load or map return leaves nothing pending
  a_ret_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && ((req_i.req_type == REQ_LOAD_RET) || (req_i.req_type == REQ_MAP_RET)))
      |=> !pend_vld_q)
    else $error("pending destination survived a return beat");

endmodule
